// File: rtl/core/lfbs_pkg.sv
package lfbs_pkg;

  localparam int STORE_DEPTH_DEF  = 32;
  localparam int LAG_DISTANCE_DEF = 3;
  localparam int WORD_BITS_DEF    = 32;

  localparam int SEED_INDEX_BITS = 5;
  localparam int SEED_WORD_BITS  = 32;

  typedef enum logic [0:0] {
    FUNC_DRAW = 1'b0,
    FUNC_SEED = 1'b1
  } func_t;

  typedef struct packed {
    logic shift;
    logic insert;
    logic seed;
  } cell_ctrl_t;

endpackage

// File: rtl/core/lfbs_cell.sv
module lfbs_cell import lfbs_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] neighbor,
  input  logic [WORD_BITS-1:0] sum,
  input  logic [WORD_BITS-1:0] seed_word,
  output logic [WORD_BITS-1:0] word
);

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctrl.seed) begin
      word <= seed_word;
    end else if (ctrl.shift) begin
      word <= ctrl.insert ? sum : neighbor;
    end
  end

endmodule

// File: rtl/core/lfbs_serializer.sv
module lfbs_serializer import lfbs_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 draw,
  input  logic [WORD_BITS-1:0] sum,
  output logic                 empty,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 random_bit
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] bit_buffer;
  logic [WORD_BITS-1:0] bit_buffer_next;
  logic [CNT_W-1:0]     bits_remaining;
  logic [CNT_W-1:0]     bits_remaining_next;
  logic                 bit_next;

  assign empty = (bits_remaining == '0);

  always_comb begin
    if (empty) begin
      bit_next            = sum[0];
      bit_buffer_next     = sum >> 1;
      bits_remaining_next = CNT_W'(WORD_BITS - 1);
    end else begin
      bit_next            = bit_buffer[0];
      bit_buffer_next     = bit_buffer >> 1;
      bits_remaining_next = bits_remaining - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_remaining <= '0;
      bit_buffer     <= '0;
      out_valid      <= 1'b0;
    end else if (draw) begin
      bits_remaining <= bits_remaining_next;
      bit_buffer     <= bit_buffer_next;
      out_valid      <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (draw) begin
      random_bit <= bit_next;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    bits_remaining <= CNT_W'(WORD_BITS))
    else $error("bit count out of range");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    draw && empty |=> bits_remaining == CNT_W'(WORD_BITS - 1))
    else $error("refill did not load a full word");

  a_rose_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(draw))
    else $error("output beat without a draw");
`endif

endmodule

// File: rtl/core/lagged_fibonacci_bit_source.sv
// Additive lagged Fibonacci bit source. Draw beats (func = 0) return one bit each,
// least significant bit of each generated word first; seed beats (func = 1) write one
// store word and return nothing. One beat is taken every cycle: the store is a ring of
// word cells that rotates by one position whenever a new word is needed, and the one
// adder producing that word sits in the same cycle as the draw, so a refill never holds up
// a draw. Draw beats stall only while a produced bit is held on a stalled output;
// seed beats are taken even then. The store resets to all zeros, so seed it before use.
module lagged_fibonacci_bit_source import lfbs_pkg::*; #(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int LAG_DISTANCE = LAG_DISTANCE_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [SEED_INDEX_BITS-1:0] seed_index,
  input  logic [SEED_WORD_BITS-1:0]  seed_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       random_bit
);

  localparam int PW    = $clog2(STORE_DEPTH);
  localparam int CW    = ((PW > SEED_INDEX_BITS) ? PW : SEED_INDEX_BITS) + 1;
  localparam int FRONT = LAG_DISTANCE % STORE_DEPTH;

  // cell k holds store entry (back_pointer + k) mod depth
  logic [WORD_BITS-1:0] words [STORE_DEPTH];
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS-1:0] seed_value;
  logic [PW-1:0]        back_pointer;
  logic [CW-1:0]        idx_w;
  logic [CW-1:0]        back_w;
  logic [CW-1:0]        pos_w;
  logic [PW-1:0]        seed_pos;
  logic                 seed_hit;
  logic                 accept;
  logic                 draw;
  logic                 seed_fire;
  logic                 empty;
  logic                 advance;

  assign in_stall  = out_valid && out_stall && (func == FUNC_DRAW);
  assign accept    = in_valid && !in_stall;
  assign draw      = accept && (func == FUNC_DRAW);
  assign seed_fire = accept && (func == FUNC_SEED) && seed_hit;
  assign advance   = draw && empty;

  assign sum        = words[0] + words[FRONT];
  assign seed_value = WORD_BITS'(seed_word);

  // map the absolute seed index onto the rotated ring
  always_comb begin
    idx_w    = CW'(seed_index);
    back_w   = CW'(back_pointer);
    seed_hit = idx_w < CW'(STORE_DEPTH);
    if (idx_w >= back_w) begin
      pos_w = idx_w - back_w;
    end else begin
      pos_w = idx_w + CW'(STORE_DEPTH) - back_w;
    end
    seed_pos = pos_w[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      back_pointer <= '0;
    end else if (advance) begin
      if (back_pointer == PW'(STORE_DEPTH - 1)) begin
        back_pointer <= '0;
      end else begin
        back_pointer <= back_pointer + PW'(1);
      end
    end
  end

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.shift  = advance;
    assign ctrl.insert = (((k + 1) % STORE_DEPTH) == FRONT);
    assign ctrl.seed   = seed_fire && (seed_pos == PW'(k));

    lfbs_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .neighbor  (words[(k + 1) % STORE_DEPTH]),
      .sum       (sum),
      .seed_word (seed_value),
      .word      (words[k])
    );
  end

  lfbs_serializer #(
    .WORD_BITS (WORD_BITS)
  ) u_serializer (
    .clk        (clk),
    .rst        (rst),
    .draw       (draw),
    .sum        (sum),
    .empty      (empty),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .random_bit (random_bit)
  );

endmodule

// File: bench/tb_top.sv
module tb_top;
  import lfbs_pkg::*;

  localparam int DEPTH       = 32;
  localparam int LAG         = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_BEATS  = 1850;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    func_t       f;
    logic [4:0]  idx;
    logic [31:0] w;
    bit          typed;
    logic        typed_bit;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  func_t                      func;
  logic [SEED_INDEX_BITS-1:0] seed_index;
  logic [SEED_WORD_BITS-1:0]  seed_word;
  logic                       out_valid;
  logic                       out_stall;
  logic                       random_bit;

  bit   cur_typed;
  logic cur_typed_bit;

  logic [31:0] lfg_store [DEPTH];
  logic [4:0]  lfg_front;
  logic [4:0]  lfg_back;
  int          lfg_bits_left;
  logic [31:0] lfg_buffer;

  logic expected_bits [$];

  int errors;
  int cycles;
  int beats_in;
  int bits_checked;
  int seeds_in;
  int send_idle;
  int recv_idle;
  bit hold_req;
  int hold_cnt;

  row_t rows [22];

  lagged_fibonacci_bit_source dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .seed_index (seed_index),
    .seed_word  (seed_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .random_bit (random_bit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic lfg_draw();
    logic b;
    if (lfg_bits_left == 0) begin
      lfg_buffer = lfg_store[lfg_front] + lfg_store[lfg_back];
      lfg_store[lfg_front] = lfg_buffer;
      lfg_front = (lfg_front == DEPTH - 1) ? 5'd0 : lfg_front + 5'd1;
      lfg_back  = (lfg_back == DEPTH - 1) ? 5'd0 : lfg_back + 5'd1;
      lfg_bits_left = 32;
    end
    lfg_bits_left = lfg_bits_left - 1;
    b = lfg_buffer[0];
    lfg_buffer = lfg_buffer >> 1;
    return b;
  endfunction

  task automatic report(input string what, input logic got, input logic want);
    $display("mismatch at cycle %0d: %s got %b want %b", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bits outstanding", cycles, expected_bits.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic pb;
    logic want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        beats_in++;
        if (func == FUNC_SEED) begin
          seeds_in++;
          lfg_store[seed_index] = seed_word;
        end else begin
          pb = lfg_draw();
          expected_bits.push_back(cur_typed ? cur_typed_bit : pb);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_bits.size() == 0) begin
          report("random_bit with nothing pending", random_bit, 1'bx);
        end else begin
          want = expected_bits.pop_front();
          bits_checked++;
          if (random_bit !== want) report("random_bit", random_bit, want);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic offer(input func_t f, input logic [4:0] idx, input logic [31:0] w,
                       input bit typed, input logic typed_bit);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    seed_index    <= idx;
    seed_word     <= w;
    cur_typed     <= typed;
    cur_typed_bit <= typed_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15)
        offer(FUNC_SEED, 5'($urandom_range(31)), $urandom, 1'b0, 1'b0);
      else
        offer(FUNC_DRAW, 5'($urandom_range(31)), $urandom, 1'b0, 1'b0);
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_DRAW;
    seed_index    = '0;
    seed_word     = '0;
    out_stall     = 1'b0;
    cur_typed     = 1'b0;
    cur_typed_bit = 1'b0;
    errors        = 0;
    cycles        = 0;
    beats_in      = 0;
    bits_checked  = 0;
    seeds_in      = 0;
    send_idle     = 35;
    recv_idle     = 53;
    hold_req      = 1'b0;
    hold_cnt      = 0;
    for (int i = 0; i < DEPTH; i++) lfg_store[i] = '0;
    lfg_front     = 5'(LAG);
    lfg_back      = 5'd0;
    lfg_bits_left = 0;
    lfg_buffer    = '0;

    // unseeded store draws zeros
    rows[0]  = '{FUNC_DRAW, 5'd0,  32'h0000_0000, 1'b1, 1'b0};
    rows[1]  = '{FUNC_DRAW, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0};
    rows[2]  = '{FUNC_DRAW, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0};
    rows[3]  = '{FUNC_SEED, 5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0};
    rows[4]  = '{FUNC_SEED, 5'd31, 32'h0000_0000, 1'b0, 1'b0};
    rows[5]  = '{FUNC_SEED, 5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0};
    rows[6]  = '{FUNC_SEED, 5'd1,  32'h0000_0001, 1'b0, 1'b0};
    rows[7]  = '{FUNC_SEED, 5'd2,  32'h8000_0000, 1'b0, 1'b0};
    rows[8]  = '{FUNC_SEED, 5'd3,  32'hAAAA_AAAA, 1'b0, 1'b0};
    rows[9]  = '{FUNC_SEED, 5'd4,  32'h5555_5555, 1'b0, 1'b0};
    rows[10] = '{FUNC_SEED, 5'd5,  32'hFFFF_FFFF, 1'b0, 1'b0};
    // seeds mid-word: buffer and pointers stay
    rows[11] = '{FUNC_DRAW, 5'd16, 32'h0000_FFFF, 1'b0, 1'b0};
    rows[12] = '{FUNC_SEED, 5'd6,  32'h0000_FFFF, 1'b0, 1'b0};
    rows[13] = '{FUNC_DRAW, 5'd0,  32'h0000_0000, 1'b0, 1'b0};
    rows[14] = '{FUNC_SEED, 5'd7,  32'hFFFF_0000, 1'b0, 1'b0};
    rows[15] = '{FUNC_SEED, 5'd30, 32'h7FFF_FFFF, 1'b0, 1'b0};
    rows[16] = '{FUNC_DRAW, 5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0};
    rows[17] = '{FUNC_DRAW, 5'd1,  32'h1234_5678, 1'b0, 1'b0};
    rows[18] = '{FUNC_SEED, 5'd8,  32'hFFFF_FFFF, 1'b0, 1'b0};
    rows[19] = '{FUNC_SEED, 5'd9,  32'h0000_0001, 1'b0, 1'b0};
    rows[20] = '{FUNC_DRAW, 5'd0,  32'h0000_0000, 1'b0, 1'b0};
    rows[21] = '{FUNC_DRAW, 5'd2,  32'hDEAD_BEEF, 1'b0, 1'b0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) offer(rows[i].f, rows[i].idx, rows[i].w, rows[i].typed, rows[i].typed_bit);

    // full seed pass, then a long random mix
    for (int i = 0; i < DEPTH; i++) offer(FUNC_SEED, 5'(i), $urandom, 1'b0, 1'b0);
    random_phase(RAND_BEATS / 3);

    send_idle = 53;
    recv_idle = 35;
    random_phase(RAND_BEATS / 3);

    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    random_phase(200);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_bits.size() != 0);
    random_phase(RAND_BEATS - 2 * (RAND_BEATS / 3) - 200);

    in_valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d beats (%0d seeds), checked %0d bits in %0d cycles",
             beats_in, seeds_in, bits_checked, cycles);
    $display("phases: sender idle, receiver idle, long output hold, no idling");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
